### sv/buddy_tree_allocator_assert.svh
// assertion macros used by the buddy tree allocator controller
`ifndef BUDDY_TREE_ALLOCATOR_ASSERT_SVH
`define BUDDY_TREE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BTA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bta_pkg.sv
// package: types, command codes and constants of the buddy tree allocator
package bta_pkg;

    localparam int TREE_LEVELS_DEF = 7;
    localparam int POOL_LG_W       = 5;
    localparam int SIZE_W          = 21;
    localparam int LEVEL_W         = 3;
    localparam int POS_W           = 6;
    localparam logic [POOL_LG_W-1:0] POOL_LG_RESET = 5'd10;
    localparam logic [POOL_LG_W-1:0] POOL_LG_MIN   = 5'd6;
    localparam logic [POOL_LG_W-1:0] POOL_LG_MAX   = 5'd20;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // datapath commands
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd4;
    localparam logic [OP_W-1:0] OP_MERGE  = 3'd5;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd6;

    typedef struct packed {
        logic                func;
        logic [SIZE_W-1:0]   req_size;
        logic [LEVEL_W-1:0]  free_level;
        logic [POS_W-1:0]    free_position;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [LEVEL_W-1:0]  alloc_level;
        logic [POS_W-1:0]    alloc_position;
        logic [SIZE_W-1:0]   largest_free_bytes;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic func;         // latched request kind
        logic bad;          // request rejected up front
        logic found;        // search chunk holds a free node
        logic search_last;  // search chunk is the last one of the level
        logic row_last;     // row walk is at the deepest level
        logic merge_stop;   // upward merge ends here
        logic scan_hit;     // scanned level has a free node
    } status_t;

endpackage

### sv/bta_datapath.sv
// datapath: free-flag rows, request registers, search, update and scan logic
module bta_datapath #(
    parameter int TREE_LEVELS = bta_pkg::TREE_LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bta_pkg::POOL_LG_W-1:0]      cfg_wdata,
    input  bta_pkg::req_t                      req,
    input  bta_pkg::cmd_t                      cmd,
    output bta_pkg::status_t                   status,
    output bta_pkg::result_t                   result
);

    localparam int LW  = (TREE_LEVELS > 2) ? $clog2(TREE_LEVELS) : 1;
    localparam int PW  = TREE_LEVELS - 1;
    localparam int W   = 1 << PW;
    localparam int IW  = TREE_LEVELS;
    localparam int CW  = (W < 64) ? W : 64;
    localparam int CWL = $clog2(CW);
    localparam int NCH = W / CW;
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;

    // one row of flags per tree level, position k of level l is bit k
    logic [W-1:0]                  rows_reg [TREE_LEVELS];
    logic [bta_pkg::POOL_LG_W-1:0] pool_lg_reg;
    logic                          func_reg;
    logic                          bad_reg;
    logic                          ok_reg;
    logic                          sib_reg;
    logic [LW-1:0]                 lvl_reg;
    logic [PW-1:0]                 pos_reg;
    logic [LW-1:0]                 row_reg;
    logic [LW-1:0]                 mlvl_reg;
    logic [PW-1:0]                 mpos_reg;
    logic [CHW-1:0]                chunk_reg;
    logic [bta_pkg::SIZE_W-1:0]    largest_reg;

    logic [bta_pkg::POOL_LG_W-1:0] pool_lg;
    logic [bta_pkg::SIZE_W-1:0]    pool;
    logic [LW-1:0]                 alloc_lvl;
    logic                          req_bad;
    logic [LW-1:0]                 rd_idx;
    logic [W-1:0]                  rd_row;
    logic [W-1:0]                  rd_valid;
    logic [W-1:0]                  rd_free;
    logic [CW-1:0]                 seg;
    logic [CWL-1:0]                seg_idx;
    logic [PW-1:0]                 found_pos;
    logic [IW-1:0]                 lo;
    logic [IW-1:0]                 hi;
    logic [W-1:0]                  range_mask;
    logic [PW-1:0]                 ppos;
    logic                          merge_cond;
    logic                          row_last;
    logic [LW-1:0]                 row_next;
    logic                          wr_en;
    logic [W-1:0]                  wr_data;

    always_comb
    begin
        if (pool_lg_reg < bta_pkg::POOL_LG_MIN)
        begin
            pool_lg = bta_pkg::POOL_LG_MIN;
        end
        else if (pool_lg_reg > bta_pkg::POOL_LG_MAX)
        begin
            pool_lg = bta_pkg::POOL_LG_MAX;
        end
        else
        begin
            pool_lg = pool_lg_reg;
        end
        pool = bta_pkg::SIZE_W'(1) << pool_lg;
    end

    // deepest level whose block still holds the request
    always_comb
    begin
        alloc_lvl = '0;
        for (int l = 0; l < TREE_LEVELS; l++)
        begin
            if ((pool >> l) >= req.req_size)
            begin
                alloc_lvl = LW'(l);
            end
        end
    end

    always_comb
    begin
        if (req.func == bta_pkg::FUNC_FREE)
        begin
            req_bad = (int'(req.free_level) >= TREE_LEVELS) ||
                      ((req.free_position >> req.free_level) != '0);
        end
        else
        begin
            req_bad = req.req_size > pool;
        end
    end

    // single row read port
    always_comb
    begin
        if (cmd.op == bta_pkg::OP_SEARCH)
        begin
            rd_idx = lvl_reg;
        end
        else if (cmd.op == bta_pkg::OP_MERGE)
        begin
            rd_idx = (mlvl_reg == '0) ? '0 : mlvl_reg - LW'(1);
        end
        else
        begin
            rd_idx = row_reg;
        end
    end

    assign rd_row = rows_reg[rd_idx];

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            rd_valid[i] = (IW'(i) >> rd_idx) == '0;
        end
    end

    assign rd_free = rd_row & rd_valid;

    // first free node of the current search chunk
    always_comb
    begin
        seg     = CW'(rd_free >> (int'(chunk_reg) << CWL));
        seg_idx = '0;
        for (int i = CW - 1; i >= 0; i--)
        begin
            if (seg[i])
            begin
                seg_idx = CWL'(i);
            end
        end
        found_pos = PW'((int'(chunk_reg) << CWL) + int'(seg_idx));
    end

    // positions of the current row covered by the target node or its ancestor
    always_comb
    begin
        if (row_reg <= lvl_reg)
        begin
            lo = IW'(pos_reg) >> (lvl_reg - row_reg);
            hi = lo + IW'(1);
        end
        else
        begin
            lo = IW'(pos_reg) << (row_reg - lvl_reg);
            hi = (IW'(pos_reg) + IW'(1)) << (row_reg - lvl_reg);
        end
        for (int i = 0; i < W; i++)
        begin
            range_mask[i] = (IW'(i) >= lo) && (IW'(i) < hi);
        end
    end

    assign ppos       = mpos_reg >> 1;
    assign merge_cond = (mlvl_reg != '0) && !rd_row[ppos] && sib_reg;
    assign row_last   = row_reg == LW'(TREE_LEVELS - 1);
    assign row_next   = row_last ? '0 : row_reg + LW'(1);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = rd_row;
        case (cmd.op)
            bta_pkg::OP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = rd_row & ~range_mask;
            end
            bta_pkg::OP_FILL:
            begin
                wr_en   = 1'b1;
                wr_data = rd_row | range_mask;
            end
            bta_pkg::OP_MERGE:
            begin
                wr_en   = merge_cond;
                wr_data = rd_row | (W'(1) << ppos);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < TREE_LEVELS; l++)
            begin
                rows_reg[l] <= '1;
            end
        end
        else if (wr_en)
        begin
            rows_reg[rd_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_lg_reg <= bta_pkg::POOL_LG_RESET;
        end
        else if (cfg_we)
        begin
            pool_lg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            ok_reg      <= 1'b0;
            sib_reg     <= 1'b0;
            lvl_reg     <= '0;
            pos_reg     <= '0;
            row_reg     <= '0;
            mlvl_reg    <= '0;
            mpos_reg    <= '0;
            chunk_reg   <= '0;
            largest_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                bta_pkg::OP_LOAD:
                begin
                    func_reg  <= req.func;
                    bad_reg   <= req_bad;
                    ok_reg    <= 1'b0;
                    chunk_reg <= '0;
                    if (req.func == bta_pkg::FUNC_FREE)
                    begin
                        lvl_reg  <= LW'(req.free_level);
                        mlvl_reg <= LW'(req.free_level);
                        pos_reg  <= PW'(req.free_position);
                        mpos_reg <= PW'(req.free_position);
                        row_reg  <= req_bad ? '0 : LW'(req.free_level);
                    end
                    else
                    begin
                        lvl_reg  <= alloc_lvl;
                        mlvl_reg <= alloc_lvl;
                        pos_reg  <= '0;
                        mpos_reg <= '0;
                        row_reg  <= '0;
                    end
                end
                bta_pkg::OP_SEARCH:
                begin
                    if (|seg)
                    begin
                        pos_reg <= found_pos;
                        ok_reg  <= 1'b1;
                    end
                    else
                    begin
                        chunk_reg <= chunk_reg + CHW'(1);
                    end
                end
                bta_pkg::OP_CLEAR:
                begin
                    row_reg <= row_next;
                end
                bta_pkg::OP_FILL:
                begin
                    row_reg <= row_next;
                    ok_reg  <= 1'b1;
                    if (row_reg == lvl_reg)
                    begin
                        sib_reg <= rd_row[pos_reg ^ PW'(1)];
                    end
                end
                bta_pkg::OP_MERGE:
                begin
                    if (merge_cond)
                    begin
                        mlvl_reg <= mlvl_reg - LW'(1);
                        mpos_reg <= ppos;
                        sib_reg  <= rd_row[ppos ^ PW'(1)];
                    end
                end
                bta_pkg::OP_SCAN:
                begin
                    row_reg <= row_next;
                    if (|rd_free)
                    begin
                        largest_reg <= pool >> rd_idx;
                    end
                    else if (row_last)
                    begin
                        largest_reg <= '0;
                    end
                end
                default:
                begin
                    row_reg <= row_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        status.func        = func_reg;
        status.bad         = bad_reg;
        status.found       = |seg;
        status.search_last = chunk_reg ==
                             CHW'(((32'd1 << lvl_reg) - 32'd1) >> CWL);
        status.row_last    = row_last;
        status.merge_stop  = !merge_cond;
        status.scan_hit    = |rd_free;
    end

    always_comb
    begin
        result.ok                 = ok_reg;
        result.alloc_level        = '0;
        result.alloc_position     = '0;
        result.largest_free_bytes = largest_reg;
        if (ok_reg && func_reg == bta_pkg::FUNC_ALLOC)
        begin
            result.alloc_level    = bta_pkg::LEVEL_W'(lvl_reg);
            result.alloc_position = bta_pkg::POS_W'(pos_reg);
        end
    end

endmodule

### sv/bta_ctrl.sv
// controller: state machine that sequences one transaction through the datapath
`include "buddy_tree_allocator_assert.svh"

module bta_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bta_pkg::status_t  status,
    output bta_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_MERGE  = 3'd5;
    localparam logic [2:0] S_SCAN   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bta_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = bta_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.bad)
                begin
                    state_next = S_SCAN;
                end
                else if (status.func == bta_pkg::FUNC_FREE)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.op = bta_pkg::OP_SEARCH;
                if (status.found)
                begin
                    state_next = S_CLEAR;
                end
                else if (status.search_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_CLEAR:
            begin
                cmd.op = bta_pkg::OP_CLEAR;
                if (status.row_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_FILL:
            begin
                cmd.op = bta_pkg::OP_FILL;
                if (status.row_last)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.op = bta_pkg::OP_MERGE;
                if (status.merge_stop)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = bta_pkg::OP_SCAN;
                if (status.scan_hit || status.row_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

    `BTA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted request did not start")
    `BTA_ASSERT_NEXT(a_done_release, done, !busy, "block stayed busy after result")
    `BTA_ASSERT_NEXT(a_found_clears, state_reg == S_SEARCH && status.found, state_reg == S_CLEAR, "found node not claimed")
    `BTA_ASSERT_NOW(a_load_idle, cmd.op == bta_pkg::OP_LOAD, !busy && start, "load outside accept")

endmodule

### sv/buddy_tree_allocator.sv
// top level: buddy allocator over one power-of-two pool kept as a tree of free flags
//
// one transaction at a time: a request is taken at a clock edge with start high and
// busy low, and exactly one result appears on result for a single cycle with done
// high; the receiver cannot stall, so it must capture result whenever done is high.
// the flags live in one row register per tree level and the controller walks them a
// level per cycle through a single row read port. an allocate decodes, searches the
// chosen level in 64-position search chunks (one chunk at the default seven
// levels), clears the claimed node, its ancestors and its subtree row by row from
// the root, then scans from the root for the largest free block; a failed allocate
// skips the clearing walk. a free decodes, fills its subtree from its level down to
// the deepest row, merges upward while the buddy is free, then scans the same way.
// pool_size_log2 must be written through cfg_we / cfg_wdata only while busy is low;
// the block itself does not enforce it. values outside 6..20 are clamped on use, and
// the flags survive a change of pool size. no clearing pass is needed after reset.
module buddy_tree_allocator #(
    parameter int TREE_LEVELS = bta_pkg::TREE_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bta_pkg::req_t                 req,
    output logic                          done,
    output bta_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [bta_pkg::POOL_LG_W-1:0] cfg_wdata
);

    // command and status between the sequencer and the flag datapath
    bta_pkg::cmd_t    cmd;
    bta_pkg::status_t status;

    bta_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // flag rows, request latch, pool size register and result registers
    bta_datapath #(
        .TREE_LEVELS (TREE_LEVELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

### dv/testbench.sv
// testbench for the buddy tree allocator: random and directed requests checked against a tree model
`timescale 1ns / 1ps

module testbench;

    localparam int LEVELS = bta_pkg::TREE_LEVELS_DEF;
    localparam int NODES = (1 << LEVELS) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 40;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    bta_pkg::req_t req;
    logic done;
    bta_pkg::result_t result;
    logic cfg_we;
    logic [bta_pkg::POOL_LG_W-1:0] cfg_wdata;

    buddy_tree_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // testbench's own view of the tree
    logic [NODES-1:0] node_free;
    logic [bta_pkg::POOL_LG_W-1:0] pool_lg;

    bta_pkg::req_t pending_reqs[$];
    bta_pkg::result_t expected_results[$];
    int errors;
    int cycles;
    int gap;
    logic hold_off;   // sender pauses until the block drains
    logic calm;       // final stretch with no idling

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic int pool_bytes();
        int lg;
        lg = pool_lg;
        if (lg < bta_pkg::POOL_LG_MIN) lg = bta_pkg::POOL_LG_MIN;
        if (lg > bta_pkg::POOL_LG_MAX) lg = bta_pkg::POOL_LG_MAX;
        return 1 << lg;
    endfunction

    // largest free block: first level from the root holding a free node
    function automatic int largest_block();
        for (int lvl = 0; lvl < LEVELS; lvl++)
            for (int k = 0; k < (1 << lvl); k++)
                if (node_free[(1 << lvl) - 1 + k]) return pool_bytes() >> lvl;
        return 0;
    endfunction

    function automatic void set_subtree(input int node, input logic v);
        int first;
        int cnt;
        first = node;
        cnt = 1;
        while (first < NODES)
        begin
            for (int k = 0; k < cnt && first + k < NODES; k++) node_free[first + k] = v;
            first = 2 * first + 1;
            cnt = cnt << 1;
        end
    endfunction

    // apply one transaction to the tree and return what the block should answer
    function automatic bta_pkg::result_t allocate_or_free(input bta_pkg::req_t r);
        bta_pkg::result_t res;
        int pool;
        int lvl;
        int node;
        int parent;
        int sib;
        int first;
        res = '0;
        pool = pool_bytes();
        if (r.func == bta_pkg::FUNC_ALLOC)
        begin
            if (int'(r.req_size) <= pool)
            begin
                lvl = LEVELS - 1;
                while (lvl > 0 && (pool >> lvl) < int'(r.req_size)) lvl--;
                first = (1 << lvl) - 1;
                for (int k = 0; k < (1 << lvl); k++)
                begin
                    if (node_free[first + k])
                    begin
                        node = first + k;
                        // ancestors lose their whole-block status
                        while (node > 0)
                        begin
                            node = (node - 1) >> 1;
                            node_free[node] = 1'b0;
                        end
                        set_subtree(first + k, 1'b0);
                        res.ok = 1'b1;
                        res.alloc_level = bta_pkg::LEVEL_W'(lvl);
                        res.alloc_position = bta_pkg::POS_W'(k);
                        break;
                    end
                end
            end
        end
        else if (int'(r.free_level) < LEVELS &&
                 int'(r.free_position) < (1 << r.free_level))
        begin
            node = (1 << r.free_level) - 1 + r.free_position;
            first = node;
            // merge upward while the buddy is free
            while (node > 0)
            begin
                parent = (node - 1) >> 1;
                sib = (node & 1) ? node + 1 : node - 1;
                if (node_free[parent] || !node_free[sib]) break;
                node_free[parent] = 1'b1;
                node = parent;
            end
            set_subtree(first, 1'b1);
            res.ok = 1'b1;
        end
        res.largest_free_bytes = bta_pkg::SIZE_W'(largest_block());
        return res;
    endfunction

    // driver: one transaction offered at a time, random idle bursts in between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            gap <= 0;
        end
        else if (!start || !busy)
        begin
            if (gap > 0)
            begin
                start <= 1'b0;
                gap <= gap - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                start <= 1'b0;
                gap <= $urandom_range(1, 8) - 1;
            end
            else if (!hold_off && pending_reqs.size() > 0)
            begin
                start <= 1'b1;
                req <= pending_reqs.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor and predictor: results checked first, then accepted requests modeled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            node_free = '1;
            pool_lg = bta_pkg::POOL_LG_RESET;
        end
        else
        begin
            cycles++;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    bta_pkg::result_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (result.ok !== exp_res.ok)
                        report_mismatch($sformatf("ok %0b want %0b", result.ok, exp_res.ok));
                    if (result.alloc_level !== exp_res.alloc_level)
                        report_mismatch($sformatf("alloc_level %0d want %0d",
                            result.alloc_level, exp_res.alloc_level));
                    if (result.alloc_position !== exp_res.alloc_position)
                        report_mismatch($sformatf("alloc_position %0d want %0d",
                            result.alloc_position, exp_res.alloc_position));
                    if (result.largest_free_bytes !== exp_res.largest_free_bytes)
                        report_mismatch($sformatf("largest_free_bytes %0d want %0d",
                            result.largest_free_bytes, exp_res.largest_free_bytes));
                end
            end
            if (start && !busy) expected_results.push_back(allocate_or_free(req));
            if (cfg_we) pool_lg = cfg_wdata;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bta_pkg::req_t alloc_req(input int size);
        bta_pkg::req_t r;
        r = '0;
        r.func = bta_pkg::FUNC_ALLOC;
        r.req_size = bta_pkg::SIZE_W'(size);
        r.free_level = bta_pkg::LEVEL_W'($urandom);
        r.free_position = bta_pkg::POS_W'($urandom);
        return r;
    endfunction

    function automatic bta_pkg::req_t free_req(input int lvl, input int pos);
        bta_pkg::req_t r;
        r = '0;
        r.func = bta_pkg::FUNC_FREE;
        r.req_size = bta_pkg::SIZE_W'($urandom);
        r.free_level = bta_pkg::LEVEL_W'(lvl);
        r.free_position = bta_pkg::POS_W'(pos);
        return r;
    endfunction

    // random transaction, mostly sized to the current pool
    function automatic bta_pkg::req_t random_req();
        int lg;
        int lvl;
        int pick;
        lg = pool_lg;
        if (lg < bta_pkg::POOL_LG_MIN) lg = bta_pkg::POOL_LG_MIN;
        if (lg > bta_pkg::POOL_LG_MAX) lg = bta_pkg::POOL_LG_MAX;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            return alloc_req($urandom_range(0, 1 << $urandom_range(0, lg)));
        end
        else if (pick < 50)
        begin
            return alloc_req($urandom_range(0, (1 << bta_pkg::SIZE_W) - 1));
        end
        else if (pick < 92)
        begin
            lvl = $urandom_range(0, 99) < 80 ? $urandom_range(3, LEVELS - 1)
                                              : $urandom_range(0, 2);
            return free_req(lvl, $urandom_range(0, (1 << lvl) - 1));
        end
        else
        begin
            // random level and position, which may be out of range
            return free_req($urandom_range(0, 7), $urandom_range(0, 63));
        end
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic write_pool(input logic [bta_pkg::POOL_LG_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [bta_pkg::POOL_LG_W-1:0] pool_settings[8];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_off = 1'b0;
        calm = 1'b0;
        errors = 0;
        cycles = 0;
        pool_settings = '{5'd6, 5'd20, 5'd0, 5'd31, 5'd13, 5'd8, 5'd17, 5'd10};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes and special cases at the reset pool size
        pending_reqs.push_back(alloc_req(0));              // zero size goes deepest
        pending_reqs.push_back(alloc_req(16));
        pending_reqs.push_back(alloc_req(1024));           // whole pool while partly used
        pending_reqs.push_back(alloc_req(1025));           // larger than the pool
        pending_reqs.push_back(alloc_req((1 << bta_pkg::SIZE_W) - 1));
        pending_reqs.push_back(free_req(6, 0));
        pending_reqs.push_back(free_req(6, 0));            // already free
        pending_reqs.push_back(free_req(7, 0));            // level out of range
        pending_reqs.push_back(free_req(2, 4));            // position out of range
        pending_reqs.push_back(free_req(6, 63));
        pending_reqs.push_back(alloc_req(1024));
        pending_reqs.push_back(alloc_req(1));              // one byte, served at the deepest level
        pending_reqs.push_back(free_req(0, 0));
        for (int k = 0; k < 3; k++) pending_reqs.push_back(alloc_req(512));
        pending_reqs.push_back(free_req(1, 1));
        pending_reqs.push_back(alloc_req(1 << 20));
        pending_reqs.push_back(free_req(0, 0));
        for (int k = 0; k < 4; k++) pending_reqs.push_back(alloc_req(0));
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            write_pool(pool_settings[p]);
            if (p == 7) calm = 1'b1;
            for (int n = 0; n < 112; n++)
            begin
                pending_reqs.push_back(random_req());
                // pause the sender once, mid-stream, until the block has answered everything
                if (p == 3 && n == 50)
                begin
                    while (pending_reqs.size() > 25 || !start) @(negedge clk);
                    hold_off = 1'b1;
                    while (expected_results.size() > 0 || start || busy) @(negedge clk);
                    hold_off = 1'b0;
                end
            end
            wait_drained();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
